### rtl/text_to_utf8_transcoder_assert.svh
// ---------------------------------------------------------------------------
// text_to_utf8_transcoder assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef TEXT_TO_UTF8_TRANSCODER_ASSERT_SVH
`define TEXT_TO_UTF8_TRANSCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define TU8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TU8_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TU8_ASSERT(lbl, prop, msg)
`define TU8_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/tu8_pkg.sv
// ---------------------------------------------------------------------------
// tu8_pkg
// shared types and constants of the utf-8 transcoder
// ---------------------------------------------------------------------------
package tu8_pkg;

  localparam logic [1:0] FmtLatin1 = 2'd0;
  localparam logic [1:0] FmtUtf16  = 2'd1;
  localparam logic [1:0] FmtUtf32  = 2'd2;

  localparam logic [1:0] FmtReset  = FmtUtf16;

  // one encoded run: byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } entry_t;

endpackage

### rtl/tu8_front.sv
// ---------------------------------------------------------------------------
// tu8_front
// accepts source units, tracks surrogate and stop state, encodes one run
// ---------------------------------------------------------------------------
`include "text_to_utf8_transcoder_assert.svh"

module tu8_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       source_format_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [31:0]      code_unit_i,
  input  logic             last_unit_i,
  output logic             push_o,
  output tu8_pkg::entry_t  push_data_o,
  input  logic             full_i
);

  logic [1:0]  fmt_q, fmt_d;
  logic [9:0]  held_bits_q, held_bits_d;
  logic        held_valid_q, held_valid_d;
  logic        stopped_q, stopped_d;

  logic        accept;
  logic [15:0] u16;
  logic [15:0] low_part;
  logic [20:0] pair_cp;
  logic [31:0] cp;
  logic        have_cp;
  logic        encodable;
  logic [1:0]  last_idx;
  logic [3:0][7:0] bytes;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && !full_i;

  assign u16      = code_unit_i[15:0];
  assign low_part = u16 - 16'hDC00;
  assign pair_cp  = {1'b0, ({held_bits_q, 10'b0} | {4'b0, low_part})} + 21'h10000;

  always_comb begin
    held_bits_d  = held_bits_q;
    held_valid_d = held_valid_q;
    stopped_d    = stopped_q;
    cp           = '0;
    have_cp      = 1'b0;
    if (!stopped_q) begin
      unique case (fmt_q)
        tu8_pkg::FmtLatin1: begin
          held_valid_d = 1'b0;
          cp           = {24'b0, code_unit_i[7:0]};
          have_cp      = 1'b1;
        end
        tu8_pkg::FmtUtf16: begin
          if (held_valid_q) begin
            cp           = {11'b0, pair_cp};
            held_valid_d = 1'b0;
            have_cp      = 1'b1;
          end else if (u16[15:11] != 5'b11011) begin
            cp      = {16'b0, u16};
            have_cp = 1'b1;
          end else if (u16[10] == 1'b0) begin
            if (!last_unit_i) begin
              held_bits_d  = u16[9:0];
              held_valid_d = 1'b1;
            end
          end else begin
            stopped_d = 1'b1;
          end
        end
        default: begin
          held_valid_d = 1'b0;
          cp           = code_unit_i;
          have_cp      = 1'b1;
        end
      endcase
      if (have_cp && (cp == 32'd0)) begin
        stopped_d = 1'b1;
      end
    end
    if (last_unit_i) begin
      held_bits_d  = '0;
      held_valid_d = 1'b0;
      stopped_d    = 1'b0;
    end
  end

  // utf-8 encoder
  always_comb begin
    bytes     = '0;
    last_idx  = 2'd0;
    encodable = 1'b1;
    priority if (cp <= 32'h7F) begin
      bytes[0] = cp[7:0];
    end else if (cp <= 32'h7FF) begin
      bytes[0] = {3'b110, cp[10:6]};
      bytes[1] = {2'b10, cp[5:0]};
      last_idx = 2'd1;
    end else if (cp <= 32'hFFFF) begin
      bytes[0] = {4'b1110, cp[15:12]};
      bytes[1] = {2'b10, cp[11:6]};
      bytes[2] = {2'b10, cp[5:0]};
      last_idx = 2'd2;
    end else if (cp <= 32'h10FFFF) begin
      bytes[0] = {5'b11110, cp[20:18]};
      bytes[1] = {2'b10, cp[17:12]};
      bytes[2] = {2'b10, cp[11:6]};
      bytes[3] = {2'b10, cp[5:0]};
      last_idx = 2'd3;
    end else begin
      encodable = 1'b0;
    end
  end

  assign push_o               = accept && !stopped_q && have_cp && (cp != 32'd0) && encodable;
  assign push_data_o.bytes    = bytes;
  assign push_data_o.last_idx = last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= tu8_pkg::FmtReset;
      held_bits_q  <= '0;
      held_valid_q <= 1'b0;
      stopped_q    <= 1'b0;
    end else begin
      fmt_q <= fmt_d;
      if (accept) begin
        held_bits_q  <= held_bits_d;
        held_valid_q <= held_valid_d;
        stopped_q    <= stopped_d;
      end
    end
  end

  assign fmt_d = cfg_valid_i ? source_format_i : fmt_q;

  // a stopped string never holds a surrogate
  `TU8_ASSERT_NEVER(a_stop_excl_held, stopped_q && held_valid_q, "held surrogate in stopped string")

endmodule

### rtl/tu8_queue.sv
// ---------------------------------------------------------------------------
// tu8_queue
// short queue of encoded runs between front and back
// ---------------------------------------------------------------------------
`include "text_to_utf8_transcoder_assert.svh"

module tu8_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tu8_pkg::entry_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output tu8_pkg::entry_t  pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  tu8_pkg::entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o      = (count_q == CntMax);
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TU8_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `TU8_ASSERT_NEVER(a_no_underflow, pop_i && !pop_valid_o, "pop from empty queue")

endmodule

### rtl/tu8_back.sv
// ---------------------------------------------------------------------------
// tu8_back
// serializes each encoded run into single bytes behind an output register
// ---------------------------------------------------------------------------
`include "text_to_utf8_transcoder_assert.svh"

module tu8_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  tu8_pkg::entry_t  pop_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       utf8_byte_o,
  output logic             run_last_o
);

  logic            cur_valid_q, cur_valid_d;
  tu8_pkg::entry_t cur_q;
  logic [1:0]      idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            out_free;
  logic            send;
  logic            send_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign send      = cur_valid_q && out_free;
  assign send_last = send && (idx_q == cur_q.last_idx);
  assign pop_o     = pop_valid_i && (!cur_valid_q || send_last);

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (send) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 1'b1;
    end
    if (send_last) begin
      cur_valid_d = 1'b0;
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_data_i;
    end
    if (send) begin
      out_byte_q <= cur_q.bytes[idx_q];
      out_last_q <= send_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign utf8_byte_o = out_byte_q;
  assign run_last_o  = out_last_q;

  // the byte index never runs past the end of the current run
  `TU8_ASSERT_NEVER(a_idx_in_run, cur_valid_q && (idx_q > cur_q.last_idx), "byte index past run")

endmodule

### rtl/text_to_utf8_transcoder.sv
// an accepted unit's run goes to the queue, then to the serializer's current
//   run register; its 1 to 4 bytes leave one by one via the output register
// throughput: one output byte per cycle while out_ready_i is high
// units that emit nothing are taken at one per cycle while the queue has room
// reset: asynchronous active low; clears queue, serializer and string state,
//   source format returns to utf-16
// ---------------------------------------------------------------------------
// text_to_utf8_transcoder
// transcodes latin-1, utf-16 or utf-32 units into a utf-8 byte stream
// ---------------------------------------------------------------------------
module text_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  source_format_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  utf8_byte_o,
  output logic        run_last_o
);

  logic            push;
  tu8_pkg::entry_t push_data;
  logic            full;
  logic            pop;
  logic            pop_valid;
  tu8_pkg::entry_t pop_data;

  tu8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .source_format_i (source_format_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_unit_i     (code_unit_i),
    .last_unit_i     (last_unit_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  tu8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data)
  );

  tu8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .utf8_byte_o (utf8_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

### sim/text_to_utf8_transcoder_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_to_utf8_transcoder_check
// watches the format, unit and byte channels, works out the utf-8 words that
// each accepted unit must produce and compares them in order with the words
// leaving the transcoder
// ---------------------------------------------------------------------------
module text_to_utf8_transcoder_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  source_format_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  utf8_byte_i,
  input  logic        run_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [15:0] HighSurrLast  = 16'hDBFF;
  localparam logic [15:0] SurrFirst     = 16'hD800;
  localparam logic [15:0] LowSurrFirst  = 16'hDC00;
  localparam logic [15:0] BmpUpperFirst = 16'hE000;
  localparam logic [31:0] SuppOffset    = 32'h10000;
  localparam logic [31:0] CodeSpaceLast = 32'h10FFFF;
  localparam logic [7:0]  Lead2         = 8'hC0;
  localparam logic [7:0]  Lead3         = 8'hE0;
  localparam logic [7:0]  Lead4         = 8'hF0;
  localparam logic [7:0]  ContMark      = 8'h80;
  localparam logic [7:0]  ContMask      = 8'h3F;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
  } utf8_word_t;

  utf8_word_t utf8_due[$];
  utf8_word_t want;
  logic [1:0] format_q    = tu8_pkg::FmtReset;
  logic [9:0] held_bits_q = '0;
  logic       held_q      = 1'b0;
  logic       stopped_q   = 1'b0;

  task automatic queue_utf8(input logic [31:0] cp);
    logic [7:0] seq [4];
    utf8_word_t w;
    int n;
    n = 0;
    if (cp <= 32'h7F) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp <= 32'h7FF) begin
      seq[0] = Lead2 | {3'b000, cp[10:6]};
      seq[1] = ContMark | (cp[7:0] & ContMask);
      n = 2;
    end else if (cp <= 32'hFFFF) begin
      seq[0] = Lead3 | {4'b0000, cp[15:12]};
      seq[1] = ContMark | ({2'b00, cp[11:6]} & ContMask);
      seq[2] = ContMark | (cp[7:0] & ContMask);
      n = 3;
    end else if (cp <= CodeSpaceLast) begin
      seq[0] = Lead4 | {5'b00000, cp[20:18]};
      seq[1] = ContMark | ({2'b00, cp[17:12]} & ContMask);
      seq[2] = ContMark | ({2'b00, cp[11:6]} & ContMask);
      seq[3] = ContMark | (cp[7:0] & ContMask);
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      w.value    = seq[k];
      w.run_last = (k == n - 1);
      utf8_due.push_back(w);
    end
  endtask

  task automatic transcode_unit(input logic [31:0] unit, input logic last);
    logic [15:0] u16;
    logic [15:0] low_part;
    logic [31:0] cp;
    logic        have_cp;
    have_cp = 1'b0;
    cp      = '0;
    u16     = unit[15:0];
    if (!stopped_q) begin
      if (format_q == tu8_pkg::FmtLatin1) begin
        held_q  = 1'b0;
        cp      = {24'd0, unit[7:0]};
        have_cp = 1'b1;
      end else if (format_q == tu8_pkg::FmtUtf16) begin
        if (held_q) begin
          low_part = u16 - LowSurrFirst;
          cp       = (({22'd0, held_bits_q} << 10) | {16'd0, low_part}) + SuppOffset;
          held_q   = 1'b0;
          have_cp  = 1'b1;
        end else if (u16 < SurrFirst || u16 >= BmpUpperFirst) begin
          cp      = {16'd0, u16};
          have_cp = 1'b1;
        end else if (u16 <= HighSurrLast) begin
          if (!last) begin
            held_bits_q = u16[9:0];
            held_q      = 1'b1;
          end
        end else begin
          stopped_q = 1'b1;
        end
      end else begin
        held_q  = 1'b0;
        cp      = unit;
        have_cp = 1'b1;
      end
      if (have_cp) begin
        if (cp == '0) stopped_q = 1'b1;
        else queue_utf8(cp);
      end
    end
    if (last) begin
      held_bits_q = '0;
      held_q      = 1'b0;
      stopped_q   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q     = tu8_pkg::FmtReset;
      held_bits_q  = '0;
      held_q       = 1'b0;
      stopped_q    = 1'b0;
      utf8_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) transcode_unit(code_unit_i, last_unit_i);
      if (cfg_valid_i && cfg_ready_i) format_q = source_format_i;
      if (out_valid_i && out_ready_i) begin
        if (utf8_due.size() == 0) begin
          $error("utf8_byte %02h run_last %0b with no word expected", utf8_byte_i, run_last_i);
          fail_count_o++;
        end else begin
          want = utf8_due.pop_front();
          if (utf8_byte_i !== want.value) begin
            $error("utf8_byte expected %02h actual %02h", want.value, utf8_byte_i);
            fail_count_o++;
          end
          if (run_last_i !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, run_last_i);
            fail_count_o++;
          end
        end
      end
      pending_o = utf8_due.size();
    end
  end

endmodule

### sim/text_to_utf8_transcoder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_to_utf8_transcoder_test
// drives strings of latin-1, utf-16 and utf-32 units into the transcoder in
// random bursts, stalls the byte side, switches the source format, also in
// mid-string, and reports the verdict from checker fail and pending counts
// ---------------------------------------------------------------------------
module text_to_utf8_transcoder_test;

  localparam logic [1:0]  FmtUtf32Alt   = 2'd3;
  localparam logic [15:0] HighSurrFirst = 16'hD800;
  localparam logic [15:0] LowSurrFirst  = 16'hDC00;
  localparam logic [15:0] SurrLast      = 16'hDFFF;
  localparam logic [15:0] SurrFlip      = 16'h2000;
  localparam int          PauseCycles   = 8;
  localparam int          PhaseUnits    = 24;

  typedef enum int {ReadyAlways, ReadyCoin, ReadyThird, ReadyBursty} ready_pattern_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic [1:0]  source_format_i = tu8_pkg::FmtReset;
  logic        in_valid_i      = 1'b0;
  logic [31:0] code_unit_i     = '0;
  logic        last_unit_i     = 1'b0;
  logic        out_ready_i     = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  utf8_byte_o;
  logic        run_last_o;

  int             fail_count;
  int             pending;
  int             burst_left  = 0;
  int             units_fed   = 0;
  ready_pattern_e ready_mode  = ReadyAlways;
  int             ready_span  = 0;
  int             ready_phase = 0;

  text_to_utf8_transcoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .source_format_i (source_format_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_unit_i     (code_unit_i),
    .last_unit_i     (last_unit_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .utf8_byte_o     (utf8_byte_o),
    .run_last_o      (run_last_o)
  );

  text_to_utf8_transcoder_check check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .source_format_i (source_format_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .code_unit_i     (code_unit_i),
    .last_unit_i     (last_unit_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .utf8_byte_i     (utf8_byte_o),
    .run_last_i      (run_last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode = ready_pattern_e'($urandom_range(0, 3));
      ready_span = $urandom_range(16, 96);
    end
    ready_span--;
    ready_phase++;
    case (ready_mode)
      ReadyAlways: out_ready_i <= 1'b1;
      ReadyCoin:   out_ready_i <= ($urandom_range(0, 1) == 1);
      ReadyThird:  out_ready_i <= (ready_phase % 3 == 0);
      default:     out_ready_i <= (ready_phase % 8 >= 5);
    endcase
  end

  task automatic put_unit(input logic [31:0] unit, input logic last);
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    code_unit_i <= unit;
    last_unit_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic hold_off_input(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic feed_unit(input logic [31:0] unit, input logic last);
    if (burst_left == 0) begin
      hold_off_input(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    units_fed++;
    put_unit(unit, last);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    hold_off_input(1);
    while (pending != 0) @(negedge clk_i);
    repeat (PauseCycles) @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    source_format_i <= fmt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic string_ends();
    return ($urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [31:0] scalar_of_length(input int nbytes);
    case (nbytes)
      1:       return $urandom_range(1, 'h7F);
      2:       return $urandom_range('h80, 'h7FF);
      3:       return $urandom_range('h800, 'hFFFF);
      default: return $urandom_range('h10000, 'h10FFFF);
    endcase
  endfunction

  task automatic send_utf16_char();
    logic [31:0] noise;
    logic [31:0] more;
    logic [15:0] cp16;
    int pick;
    noise = $urandom;
    more  = $urandom;
    pick  = $urandom_range(0, 19);
    if (pick < 7) begin
      cp16 = 16'(scalar_of_length($urandom_range(1, 3)));
      if (cp16 >= HighSurrFirst && cp16 <= SurrLast) cp16 = cp16 ^ SurrFlip;
      feed_unit({noise[31:16], cp16}, string_ends());
    end else if (pick < 14) begin
      feed_unit({noise[31:16], HighSurrFirst | {6'd0, noise[9:0]}}, string_ends());
      feed_unit({more[31:16], LowSurrFirst | {6'd0, more[9:0]}}, string_ends());
    end else if (pick == 14) begin
      feed_unit({noise[31:16], HighSurrFirst | {6'd0, noise[9:0]}}, 1'b0);
      feed_unit(more, string_ends());
    end else if (pick == 15) begin
      feed_unit({noise[31:16], LowSurrFirst | {6'd0, noise[9:0]}}, string_ends());
    end else if (pick == 16) begin
      feed_unit({noise[31:16], 16'h0000}, string_ends());
    end else if (pick == 17) begin
      feed_unit({noise[31:16], HighSurrFirst | {6'd0, noise[9:0]}}, 1'b1);
    end else begin
      feed_unit(noise, string_ends());
    end
  endtask

  task automatic send_utf32_char();
    logic [31:0] noise;
    int pick;
    noise = $urandom;
    pick  = $urandom_range(0, 17);
    if (pick < 12) feed_unit(scalar_of_length($urandom_range(1, 4)), string_ends());
    else if (pick == 12) feed_unit($urandom_range('h110000, 'hFFFFFFFF), string_ends());
    else if (pick == 13) feed_unit({16'd0, HighSurrFirst | {5'd0, noise[10:0]}}, string_ends());
    else if (pick == 14) feed_unit('0, string_ends());
    else feed_unit(noise, string_ends());
  endtask

  task automatic send_latin1_char();
    logic [31:0] noise;
    noise = $urandom;
    if ($urandom_range(0, 19) == 0) feed_unit({noise[31:8], 8'h00}, string_ends());
    else feed_unit(noise, string_ends());
  endtask

  initial begin
    logic [1:0] plan [6];
    int phase_end;
    plan = '{tu8_pkg::FmtUtf32, tu8_pkg::FmtLatin1, tu8_pkg::FmtUtf16, FmtUtf32Alt,
             tu8_pkg::FmtUtf16, tu8_pkg::FmtUtf32};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // utf-16 straight out of reset
    put_unit(32'h0000_0041, 1'b0);
    put_unit(32'h0000_0080, 1'b0);
    put_unit(32'h0000_07FF, 1'b0);
    put_unit(32'h0000_0800, 1'b0);
    put_unit(32'h0000_E000, 1'b0);
    put_unit(32'h0000_FFFF, 1'b0);
    put_unit(32'h0000_D800, 1'b0);
    put_unit(32'h0000_DC00, 1'b0);
    put_unit(32'h0000_DBFF, 1'b0);
    put_unit(32'h0000_DFFF, 1'b0);
    put_unit(32'h0000_D83D, 1'b0);
    put_unit(32'h0000_0041, 1'b0);
    put_unit(32'h0000_DBFF, 1'b1);
    put_unit(32'h0000_DC00, 1'b0);
    put_unit(32'h0000_0042, 1'b1);
    put_unit(32'hFFFF_0000, 1'b1);
    put_unit(32'h0000_D800, 1'b0);
    // held surrogate dropped by the format change
    set_format(tu8_pkg::FmtLatin1);
    put_unit(32'hFFFF_FFFF, 1'b0);
    put_unit(32'h1234_5600, 1'b1);
    set_format(tu8_pkg::FmtUtf32);
    put_unit(32'h0000_007F, 1'b0);
    put_unit(32'h0011_0000, 1'b0);
    put_unit(32'h0000_DFFF, 1'b0);
    put_unit(32'h0010_FFFF, 1'b1);
    set_format(FmtUtf32Alt);
    put_unit(32'hFFFF_FFFF, 1'b0);
    put_unit(32'h0001_F600, 1'b1);

    foreach (plan[p]) begin
      set_format(plan[p]);
      phase_end = units_fed + PhaseUnits;
      while (units_fed < phase_end) begin
        if (plan[p] == tu8_pkg::FmtLatin1) send_latin1_char();
        else if (plan[p] == tu8_pkg::FmtUtf16) send_utf16_char();
        else send_utf32_char();
      end
    end

    hold_off_input(1);
    while (pending != 0) @(negedge clk_i);
    repeat (PauseCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[text_to_utf8_transcoder] OK");
    end else begin
      $display("[text_to_utf8_transcoder] ERROR");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("[text_to_utf8_transcoder] ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tu8_pkg.sv
rtl/tu8_front.sv
rtl/tu8_queue.sv
rtl/tu8_back.sv
rtl/text_to_utf8_transcoder.sv
sim/text_to_utf8_transcoder_check.sv
sim/text_to_utf8_transcoder_test.sv
